[hw/rtl/nhlt_pkg.sv]
// Shared types and constants for the node heartbeat liveness table.
// Used by the controller, the datapath and the top level; depends on nothing.
package nhlt_pkg;

  localparam int NodeSlots = 16;
  localparam int SlotW     = (NodeSlots > 1) ? $clog2(NodeSlots) : 1;

  localparam int AddrW  = 48;
  localparam int TypeW  = 24;
  localparam int TimeW  = 32;
  localparam int CfgW   = 32;
  localparam int CfgIdxW = 2;
  localparam int InDataW  = 104;  // address, type and time, whole bytes
  localparam int OutDataW = 8;    // seven result bits, padded to a byte

  localparam logic [TimeW-1:0] DeadTimeoutReset  = 32'd300000;
  localparam logic [TimeW-1:0] LagTimeoutReset   = 32'd60000;
  localparam logic [TimeW-1:0] SirenIntervalReset = 32'd10000;

  typedef enum logic [1:0] {
    KIND_PING   = 2'd0,
    KIND_SCAN   = 2'd1,
    KIND_QSTATE = 2'd2,
    KIND_QTYPE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    HEALTH_ONLINE  = 2'd0,
    HEALTH_LAGGING = 2'd1,
    HEALTH_DEAD    = 2'd2,
    HEALTH_RSVD    = 2'd3
  } health_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEAD_TIMEOUT   = 2'd0,
    REG_LAG_TIMEOUT    = 2'd1,
    REG_SIREN_INTERVAL = 2'd2,
    REG_NONE           = 2'd3
  } reg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             start;   // latch a new transaction, clear walk results
    logic             step;    // visit the slot below
    logic [SlotW-1:0] slot;
    logic             finish;  // commit table updates and load the result
  } nhlt_cmd_t;

endpackage

[hw/rtl/node_heartbeat_liveness_table_top.sv]
// Node heartbeat liveness table, top level. A transaction walks all 16 slots,
// one per cycle, in the single slot compare unit; a finish state then commits
// and loads the result. No new transaction is taken until that commit. A result
// not yet taken holds the commit. Reset (asynchronous, active low) clears the
// valid bits, emergency, siren time and output valid, and loads the limit
// registers with their defaults.
module node_heartbeat_liveness_table_top import nhlt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // node_address, module_type, now_ms
  input  logic [1:0]          s_axis_tuser,  // kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // node_health[1:0], node_found, table_full, type_present, emergency,
  // siren_pulse, one zero pad bit
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  nhlt_cmd_t cmd;

  nhlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  nhlt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_kind_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[hw/rtl/nhlt_ctrl.sv]
// Controller of the liveness table: accepts a transaction, walks all slots,
// commits and hands the result to the output register. Uses nhlt_pkg.
module nhlt_ctrl import nhlt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output nhlt_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             out_valid_q, out_valid_d;
  logic             start, out_free, finish;

  assign in_ready_o = (state_q == ST_IDLE);
  assign start      = in_valid_i && in_ready_o;
  // The output register may take a new result once the old one is gone.
  assign out_free   = !out_valid_q || out_ready_i;
  assign finish     = (state_q == ST_FINISH) && out_free;

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    case (state_q)
      ST_IDLE: begin
        slot_d = '0;
        if (start) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (slot_q == SlotW'(NodeSlots - 1)) begin
          state_d = ST_FINISH;
        end else begin
          slot_d = slot_q + SlotW'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.start   = start;
  assign cmd_o.step    = (state_q == ST_WALK);
  assign cmd_o.slot    = slot_q;
  assign cmd_o.finish  = finish;

endmodule

[hw/rtl/nhlt_datapath.sv]
// Datapath of the liveness table: node table, limit registers, per-slot
// compare and ageing logic, and the result register. Uses nhlt_pkg.
module nhlt_datapath import nhlt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nhlt_cmd_t           cmd_i,
  input  logic [1:0]          in_kind_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  output logic [OutDataW-1:0] out_data_o
);

  // Limit registers
  logic [TimeW-1:0] dead_q, lag_q, siren_ivl_q;

  // Node table; only the valid bits are reset.
  logic [NodeSlots-1:0] valid_q;
  logic [AddrW-1:0]     addr_tab_q   [NodeSlots];
  logic [TypeW-1:0]     type_tab_q   [NodeSlots];
  logic [TimeW-1:0]     seen_tab_q   [NodeSlots];
  health_e              health_tab_q [NodeSlots];

  logic             emerg_q;
  logic [TimeW-1:0] last_siren_q;

  // Latched transaction
  kind_e            kind_q;
  logic [AddrW-1:0] addr_q;
  logic [TypeW-1:0] type_q;
  logic [TimeW-1:0] now_q;

  // Walk results
  logic             hit_q, free_q, any_q;
  logic [SlotW-1:0] hit_idx_q, free_idx_q;
  health_e          hit_health_q;

  logic [OutDataW-1:0] out_q;

  // Per-slot view
  logic             s_valid, s_addr_hit, s_type_hit;
  logic [TimeW-1:0] s_gap;

  // Commit values
  logic             siren;
  logic [TimeW-1:0] siren_gap;
  health_e          res_health;
  logic             res_found, res_full, res_tpres, res_emerg;

  assign s_valid    = valid_q[cmd_i.slot];
  assign s_addr_hit = s_valid && (addr_tab_q[cmd_i.slot] == addr_q);
  assign s_type_hit = s_valid && (type_tab_q[cmd_i.slot] == type_q);
  assign s_gap      = now_q - seen_tab_q[cmd_i.slot];

  assign siren_gap  = now_q - last_siren_q;
  assign siren      = (kind_q == KIND_SCAN) && any_q && (siren_gap > siren_ivl_q);

  always_comb begin
    res_health = HEALTH_ONLINE;
    res_found  = 1'b0;
    res_full   = 1'b0;
    res_tpres  = 1'b0;
    res_emerg  = emerg_q;
    case (kind_q)
      KIND_PING: begin
        if (hit_q || free_q) begin
          res_found = 1'b1;
        end else begin
          res_health = HEALTH_DEAD;
          res_full   = 1'b1;
        end
      end
      KIND_SCAN: begin
        res_emerg = any_q;
      end
      KIND_QSTATE: begin
        res_found  = hit_q;
        res_health = hit_q ? hit_health_q : HEALTH_DEAD;
      end
      KIND_QTYPE: begin
        res_tpres = any_q;
      end
      default: begin
        res_health = HEALTH_ONLINE;
      end
    endcase
  end

  // Control-side state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_q       <= DeadTimeoutReset;
      lag_q        <= LagTimeoutReset;
      siren_ivl_q  <= SirenIntervalReset;
      valid_q      <= '0;
      emerg_q      <= 1'b0;
      last_siren_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_DEAD_TIMEOUT:   dead_q      <= cfg_data_i;
          REG_LAG_TIMEOUT:    lag_q       <= cfg_data_i;
          REG_SIREN_INTERVAL: siren_ivl_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.finish) begin
        if ((kind_q == KIND_PING) && !hit_q && free_q) begin
          valid_q[free_idx_q] <= 1'b1;
        end
        if (kind_q == KIND_SCAN) begin
          emerg_q <= any_q;
        end
        if (siren) begin
          last_siren_q <= now_q;
        end
      end
    end
  end

  // Table payload, walk registers and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q  <= kind_e'(in_kind_i);
      addr_q  <= in_data_i[AddrW-1:0];
      type_q  <= in_data_i[AddrW +: TypeW];
      now_q   <= in_data_i[AddrW+TypeW +: TimeW];
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      any_q   <= 1'b0;
    end
    if (cmd_i.step) begin
      if (s_addr_hit && !hit_q) begin
        hit_q        <= 1'b1;
        hit_idx_q    <= cmd_i.slot;
        hit_health_q <= health_tab_q[cmd_i.slot];
      end
      if (!s_valid && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= cmd_i.slot;
      end
      if ((kind_q == KIND_SCAN) && s_valid) begin
        if (s_gap > dead_q) begin
          health_tab_q[cmd_i.slot] <= HEALTH_DEAD;
          any_q                    <= 1'b1;
        end else if (s_gap > lag_q) begin
          health_tab_q[cmd_i.slot] <= HEALTH_LAGGING;
        end
      end
      if ((kind_q == KIND_QTYPE) && s_type_hit) begin
        any_q <= 1'b1;
      end
    end
    if (cmd_i.finish) begin
      if (kind_q == KIND_PING) begin
        if (hit_q) begin
          seen_tab_q[hit_idx_q]   <= now_q;
          health_tab_q[hit_idx_q] <= HEALTH_ONLINE;
        end else if (free_q) begin
          addr_tab_q[free_idx_q]   <= addr_q;
          type_tab_q[free_idx_q]   <= type_q;
          seen_tab_q[free_idx_q]   <= now_q;
          health_tab_q[free_idx_q] <= HEALTH_ONLINE;
        end
      end
      out_q <= {1'b0, siren, res_emerg, res_tpres, res_full, res_found, res_health};
    end
  end

  assign out_data_o = out_q;

endmodule

[tb/node_heartbeat_liveness_table_checker.sv]
// Checker for the node heartbeat liveness table: predicts every result from
// the accepted transactions and register writes, and compares the outputs.
// Depends on nhlt_pkg for widths, kinds, health codes and register indexes.
module node_heartbeat_liveness_table_checker import nhlt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // node_address, module_type, now_ms
  input  logic [1:0]          s_axis_tuser,  // kind
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // node_health[1:0], node_found, table_full, type_present, emergency,
  // siren_pulse, one zero pad bit
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);

  typedef struct packed {
    logic    pad;
    logic    siren_pulse;
    logic    emergency;
    logic    type_present;
    logic    table_full;
    logic    node_found;
    health_e node_health;
  } liveness_res_t;

  logic [CfgW-1:0]  dead_limit;
  logic [CfgW-1:0]  lag_limit;
  logic [CfgW-1:0]  siren_gap_limit;

  logic             node_valid  [NodeSlots];
  logic [AddrW-1:0] node_addr   [NodeSlots];
  logic [TypeW-1:0] node_type   [NodeSlots];
  logic [TimeW-1:0] node_seen   [NodeSlots];
  health_e          node_health [NodeSlots];
  logic             alarm_on;
  logic [TimeW-1:0] siren_last;

  liveness_res_t    awaited_results [$];

  function automatic int find_node(logic [AddrW-1:0] addr);
    int hit;
    hit = -1;
    for (int i = 0; i < NodeSlots; i++) begin
      if (hit < 0 && node_valid[i] && node_addr[i] == addr) hit = i;
    end
    return hit;
  endfunction

  // Applies one transaction to the shadow table and returns its result.
  function automatic liveness_res_t apply_transaction(kind_e kind, logic [AddrW-1:0] addr,
                                                      logic [TypeW-1:0] mtype,
                                                      logic [TimeW-1:0] now);
    liveness_res_t r;
    int            hit;
    logic          any_dead;
    logic [TimeW-1:0] gap;
    r        = '0;
    any_dead = 1'b0;
    case (kind)
      KIND_PING: begin
        hit = find_node(addr);
        if (hit < 0) begin
          for (int i = 0; i < NodeSlots; i++) begin
            if (hit < 0 && !node_valid[i]) hit = i;
          end
          if (hit >= 0) begin
            node_addr[hit]  = addr;
            node_type[hit]  = mtype;
            node_valid[hit] = 1'b1;
          end
        end
        if (hit >= 0) begin
          node_seen[hit]   = now;
          node_health[hit] = HEALTH_ONLINE;
          r.node_health    = HEALTH_ONLINE;
          r.node_found     = 1'b1;
        end else begin
          r.node_health = HEALTH_DEAD;
          r.table_full  = 1'b1;
        end
      end
      KIND_SCAN: begin
        for (int i = 0; i < NodeSlots; i++) begin
          if (node_valid[i]) begin
            gap = now - node_seen[i];
            if (gap > dead_limit) begin
              node_health[i] = HEALTH_DEAD;
              any_dead       = 1'b1;
            end else if (gap > lag_limit) begin
              node_health[i] = HEALTH_LAGGING;
            end
          end
        end
        alarm_on = any_dead;
        if (alarm_on && (now - siren_last) > siren_gap_limit) begin
          siren_last    = now;
          r.siren_pulse = 1'b1;
        end
      end
      KIND_QSTATE: begin
        hit = find_node(addr);
        if (hit >= 0) begin
          r.node_health = node_health[hit];
          r.node_found  = 1'b1;
        end else begin
          r.node_health = HEALTH_DEAD;
        end
      end
      default: begin
        for (int i = 0; i < NodeSlots; i++) begin
          if (node_valid[i] && node_type[i] == mtype) r.type_present = 1'b1;
        end
      end
    endcase
    r.emergency = alarm_on;
    return r;
  endfunction

  task automatic flag_field(string name, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    liveness_res_t want;
    liveness_res_t got;
    if (!rst_ni) begin
      dead_limit      = DeadTimeoutReset;
      lag_limit       = LagTimeoutReset;
      siren_gap_limit = SirenIntervalReset;
      for (int i = 0; i < NodeSlots; i++) node_valid[i] = 1'b0;
      alarm_on   = 1'b0;
      siren_last = '0;
      awaited_results.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_DEAD_TIMEOUT:   dead_limit      = cfg_data_i;
          REG_LAG_TIMEOUT:    lag_limit       = cfg_data_i;
          REG_SIREN_INTERVAL: siren_gap_limit = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(apply_transaction(kind_e'(s_axis_tuser),
                                                    s_axis_tdata[AddrW-1:0],
                                                    s_axis_tdata[AddrW+TypeW-1:AddrW],
                                                    s_axis_tdata[InDataW-1:AddrW+TypeW]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = liveness_res_t'(m_axis_tdata);
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, m_axis_tdata);
          errors_o++;
        end else begin
          want = awaited_results.pop_front();
          if (got.node_health !== want.node_health)
            flag_field("node_health", want.node_health, got.node_health);
          if (got.node_found !== want.node_found)
            flag_field("node_found", want.node_found, got.node_found);
          if (got.table_full !== want.table_full)
            flag_field("table_full", want.table_full, got.table_full);
          if (got.type_present !== want.type_present)
            flag_field("type_present", want.type_present, got.type_present);
          if (got.emergency !== want.emergency)
            flag_field("emergency", want.emergency, got.emergency);
          if (got.siren_pulse !== want.siren_pulse)
            flag_field("siren_pulse", want.siren_pulse, got.siren_pulse);
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

[tb/node_heartbeat_liveness_table_top_test.sv]
// Testbench top for the node heartbeat liveness table: drives pings, scans
// and queries under several register settings and idling phases.
// Depends on nhlt_pkg, the block and node_heartbeat_liveness_table_checker.
module node_heartbeat_liveness_table_top_test;
  import nhlt_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int AddrPool   = 20;
  localparam int HoldCycles = 400;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgW-1:0]     cfg_data_i    = '0;

  int fail_count;
  int open_results;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int cycle_count    = 0;

  logic [TimeW-1:0] wall_ms;
  logic [AddrW-1:0] addr_pool [AddrPool];
  logic [TypeW-1:0] type_set  [4];

  node_heartbeat_liveness_table_top uut (.*);

  node_heartbeat_liveness_table_checker checker_i (
    .errors_o (fail_count),
    .pending_o(open_results),
    .*
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("node_heartbeat_liveness_table_top_test: done, errors");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        holds_served++;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input kind_e kind, input logic [AddrW-1:0] addr,
                           input logic [TypeW-1:0] mtype, input logic [TimeW-1:0] now);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 30);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, mtype, addr};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (open_results != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
  endtask

  task automatic random_item();
    kind_e            kind;
    logic [AddrW-1:0] addr;
    logic [TypeW-1:0] mtype;
    logic [TimeW-1:0] now;
    logic [63:0]      wide;
    int               roll;
    roll = $urandom_range(99);
    kind = (roll < 40) ? KIND_PING : (roll < 65) ? KIND_SCAN :
           (roll < 85) ? KIND_QSTATE : KIND_QTYPE;
    wide = {$urandom, $urandom};
    if ($urandom_range(99) < 85) addr = addr_pool[$urandom_range(AddrPool - 1)];
    else addr = wide[AddrW-1:0];
    wide = {$urandom, $urandom};
    if ($urandom_range(99) < 75) mtype = type_set[$urandom_range(3)];
    else mtype = wide[TypeW-1:0];
    // Time mostly moves forward in steps around the limits; now and then it jumps.
    roll = $urandom_range(99);
    if (roll < 70) wall_ms += $urandom_range(4000);
    else if (roll < 90) wall_ms += $urandom_range(80000);
    else if (roll < 97) wall_ms += $urandom_range(400000);
    now = (roll >= 97) ? $urandom : wall_ms;
    send_item(kind, addr, mtype, now);
  endtask

  task automatic run_phase(input logic [CfgW-1:0] dead, input logic [CfgW-1:0] lag,
                           input logic [CfgW-1:0] siren, input int s_idle,
                           input int r_stall, input int n_items, input bit long_hold);
    settle_block();
    write_reg(REG_DEAD_TIMEOUT, dead);
    write_reg(REG_LAG_TIMEOUT, lag);
    write_reg(REG_SIREN_INTERVAL, siren);
    write_reg(REG_NONE, $urandom);
    cfg_we_i       <= 1'b0;
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    if (long_hold) hold_requests++;
    repeat (n_items) random_item();
  endtask

  initial begin
    logic [63:0] wide;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < AddrPool; i++) begin
      wide         = {$urandom, $urandom};
      addr_pool[i] = wide[AddrW-1:0];
    end
    type_set[0] = '0;
    type_set[1] = '1;
    type_set[2] = 24'h534E53;
    type_set[3] = TypeW'($urandom_range(24'hFFFFFF));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset limits.
    send_item(KIND_QSTATE, '0, '0, 32'd0);            // unknown address reads dead
    send_item(KIND_QTYPE,  '0, '0, 32'd0);
    send_item(KIND_SCAN,   '0, '0, 32'd0);            // empty table
    send_item(KIND_PING,   '0, '1, 32'd100);
    send_item(KIND_PING,   '1, '0, 32'd200);
    send_item(KIND_PING,   '0, 24'h123456, 32'd300);  // known address keeps its type
    send_item(KIND_QTYPE,  '0, '1, 32'd310);
    send_item(KIND_QTYPE,  '0, 24'h123456, 32'd320);
    send_item(KIND_QTYPE,  '1, '0, 32'd330);
    send_item(KIND_SCAN,   '0, '0, 32'd60400);        // both nodes lagging
    send_item(KIND_QSTATE, '0, '0, 32'd60500);
    send_item(KIND_SCAN,   '0, '0, 32'd300250);       // one dead: emergency and siren
    send_item(KIND_SCAN,   '0, '0, 32'd305000);       // inside the siren interval
    send_item(KIND_SCAN,   '0, '0, 32'd316000);       // interval passed, siren again
    send_item(KIND_QSTATE, '1, '0, 32'd316010);
    send_item(KIND_PING,   '0, '0, 32'd316050);
    send_item(KIND_PING,   '1, '0, 32'd316100);
    send_item(KIND_SCAN,   '0, '0, 32'd316200);       // emergency clears
    send_item(KIND_PING,   48'h8000_0000_0001, 24'h414243, 32'hFFFF_FF00);
    send_item(KIND_SCAN,   '0, '0, 32'h0000_0100);    // time wraps around
    send_item(KIND_QSTATE, 48'h8000_0000_0001, '0, 32'hFFFF_FFFF);
    send_item(KIND_QSTATE, 48'h0000_0000_1234, '1, 32'hFFFF_FFFF);

    wall_ms = $urandom;
    run_phase(DeadTimeoutReset, LagTimeoutReset, SirenIntervalReset, 0, 0, 130, 1'b0);
    run_phase('0, '0, '0, 51, 0, 130, 1'b0);
    run_phase('1, '1, '1, 0, 51, 130, 1'b1);
    run_phase(32'd40000, 32'd8000, 32'd5000, 9, 9, 130, 1'b0);
    // Dead limit below the lag limit, no siren spacing.
    run_phase(32'd15000, 32'd90000, 32'd0, 0, 0, 130, 1'b1);

    settle_block();
    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("node_heartbeat_liveness_table_top_test: done, clean");
    end else begin
      $display("node_heartbeat_liveness_table_top_test: done, errors");
    end
    $finish;
  end

endmodule
